// File: rtl/area_average_line_resampler_macros.svh
// Assertion macros for the area-average line resampler.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef AREA_AVERAGE_LINE_RESAMPLER_MACROS_SVH
`define AREA_AVERAGE_LINE_RESAMPLER_MACROS_SVH

// Same-cycle implication.
`define AALR_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("resampler assertion failed");

// Next-cycle implication.
`define AALR_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("resampler assertion failed");

`endif

// File: rtl/aalr_pkg.sv
// Shared types and constants of the area-average line resampler.
// No dependencies; every other file but the macro header imports it.
package aalr_pkg;

   localparam int CHAN_W         = 8;
   localparam int NUM_CHAN       = 3;
   localparam int CH_RED         = 0;
   localparam int CH_GREEN       = 1;
   localparam int CH_BLUE        = 2;
   localparam int REG_W          = 13;
   localparam int CSR_IDX_W      = 2;
   localparam int UPSCALE_SHIFT  = 5;
   localparam int DEF_MAX_SIZE   = 4096;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SRC_SIZE = 0,
      REG_DST_SIZE = 1
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MAC,
      ST_DIV,
      ST_SEND,
      ST_FINISH
   } state_type;

   typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_type;

   typedef struct packed {
      logic start;
      logic clear;
   } mac_ctl_type;

endpackage

// File: rtl/aalr_intf.sv
// Handshake interfaces of the resampler: pixel input, pixel output and
// register write channel. Depends on aalr_pkg.
interface aalr_req_if import aalr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface aalr_rsp_if import aalr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              run_last;
   logic              line_end;

   modport source (output valid, red_out, green_out, blue_out, run_last, line_end,
                   input ready);
   modport sink (input valid, red_out, green_out, blue_out, run_last, line_end,
                 output ready);
endinterface

interface aalr_csr_if import aalr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [REG_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/area_average_line_resampler.sv
// Area-average line resampler. Each pixel is checked, then each output that it
// completes takes a bit-serial multiply, a bit-serial divide and a send; an open
// partial output takes a final multiply before the pixel finishes. The output
// register lets the next pixel enter while a beat waits; a beat finding it still
// full waits until it drains.
// Synchronous reset sets both sizes to 1, clears sums and counts; a write restarts.
`include "area_average_line_resampler_macros.svh"

module area_average_line_resampler import aalr_pkg::*; #(
   parameter int MAX_SIZE = DEF_MAX_SIZE
) (
   input  logic              clock,
   input  logic              reset,
   aalr_req_if.sink          req_ch,
   aalr_rsp_if.source        rsp_ch,
   aalr_csr_if.sink          csr_ch
);

   localparam int SZ_W  = $clog2(MAX_SIZE + 1);
   localparam int ACC_W = $clog2(((2 ** CHAN_W) - 1) * MAX_SIZE + 1);
   localparam int CMP_W = (REG_W > SZ_W) ? REG_W : SZ_W;
   localparam int SUM_W = SZ_W + 1;
   localparam int UP_W  = SZ_W + UPSCALE_SHIFT;

   state_type                      state_ff, state_in;
   logic [REG_W-1:0]               src_ff, src_in;
   logic [REG_W-1:0]               dst_ff, dst_in;
   pixel_type                      pix_ff, pix_in;
   logic [SZ_W-1:0]                left_ff, left_in;
   logic [SZ_W-1:0]                weight_ff, weight_in;
   logic                           pend_ff, pend_in;
   logic [SZ_W-1:0]                units_ff, units_in;
   logic [SZ_W-1:0]                src_cnt_ff, src_cnt_in;
   logic [SZ_W-1:0]                out_cnt_ff, out_cnt_in;
   logic                           run_last_ff, run_last_in;
   logic                           line_end_ff, line_end_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pixel_type                      rsp_pix_ff;
   logic                           rsp_run_ff;
   logic                           rsp_end_ff;

   logic [CMP_W-1:0]               src_ext, dst_ext;
   logic [SZ_W-1:0]                s_used, d_raw, d_used;
   logic [UP_W-1:0]                d_cap;
   logic                           full;
   logic [SZ_W-1:0]                left_next;
   logic                           csr_take;
   logic                           load_rsp;
   mac_ctl_type                    mac_ctl;
   logic                           mac_busy;
   logic [NUM_CHAN-1:0][ACC_W-1:0] mac_acc;
   logic                           div_start;
   logic                           div_busy;
   pixel_type                      div_quot;

   // Effective sizes: zero reads as one, large values saturate, and the
   // output count is capped at 32 outputs per source pixel.
   always_comb begin
      src_ext = CMP_W'(src_ff);
      dst_ext = CMP_W'(dst_ff);
      if (src_ext == '0) begin
         s_used = SZ_W'(1);
      end else if (src_ext > CMP_W'(MAX_SIZE)) begin
         s_used = SZ_W'(MAX_SIZE);
      end else begin
         s_used = SZ_W'(src_ext);
      end
      if (dst_ext == '0) begin
         d_raw = SZ_W'(1);
      end else if (dst_ext > CMP_W'(MAX_SIZE)) begin
         d_raw = SZ_W'(MAX_SIZE);
      end else begin
         d_raw = SZ_W'(dst_ext);
      end
      d_cap = UP_W'(s_used) << UPSCALE_SHIFT;
      if (UP_W'(d_raw) > d_cap) begin
         d_used = SZ_W'(d_cap);
      end else begin
         d_used = d_raw;
      end
   end

   assign full      = (SUM_W'(units_ff) + SUM_W'(left_ff)) >= SUM_W'(s_used);
   assign left_next = left_ff - weight_ff;
   assign csr_take  = csr_ch.valid && csr_ch.ready;

   assign csr_ch.ready = (state_ff == ST_IDLE);
   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_ch.valid;

   always_comb begin
      state_in    = state_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      pix_in      = pix_ff;
      left_in     = left_ff;
      weight_in   = weight_ff;
      pend_in     = pend_ff;
      units_in    = units_ff;
      src_cnt_in  = src_cnt_ff;
      out_cnt_in  = out_cnt_ff;
      run_last_in = run_last_ff;
      line_end_in = line_end_ff;
      mac_ctl     = '0;
      div_start   = 1'b0;
      load_rsp    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid && req_ch.ready) begin
               pix_in[CH_RED]   = req_ch.red_in;
               pix_in[CH_GREEN] = req_ch.green_in;
               pix_in[CH_BLUE]  = req_ch.blue_in;
               left_in          = d_used;
               state_in         = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (full) begin
               weight_in     = s_used - units_ff;
               pend_in       = 1'b1;
               mac_ctl.start = 1'b1;
               state_in      = ST_MAC;
            end else if (left_ff != '0) begin
               weight_in     = left_ff;
               pend_in       = 1'b0;
               mac_ctl.start = 1'b1;
               state_in      = ST_MAC;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_MAC: begin
            if (!mac_busy) begin
               if (pend_ff) begin
                  // The open output is complete: hand its sums to the divider.
                  div_start     = 1'b1;
                  mac_ctl.clear = 1'b1;
                  units_in      = '0;
                  left_in       = left_next;
                  out_cnt_in    = out_cnt_ff + SZ_W'(1);
                  run_last_in   = left_next < s_used;
                  line_end_in   = (out_cnt_ff + SZ_W'(1)) >= d_used;
                  state_in      = ST_DIV;
               end else begin
                  units_in = units_ff + left_ff;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               load_rsp = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_FINISH: begin
            src_cnt_in = src_cnt_ff + SZ_W'(1);
            if ((src_cnt_ff + SZ_W'(1)) >= s_used) begin
               src_cnt_in    = '0;
               out_cnt_in    = '0;
               units_in      = '0;
               mac_ctl.clear = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_take) begin
         unique case (csr_ch.index)
            REG_SRC_SIZE: src_in = csr_ch.data;
            REG_DST_SIZE: dst_in = csr_ch.data;
            default: ;
         endcase
         if ((csr_ch.index == REG_SRC_SIZE) || (csr_ch.index == REG_DST_SIZE)) begin
            src_cnt_in    = '0;
            out_cnt_in    = '0;
            units_in      = '0;
            mac_ctl.clear = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_ff       <= REG_W'(1);
         dst_ff       <= REG_W'(1);
         pend_ff      <= 1'b0;
         units_ff     <= '0;
         src_cnt_ff   <= '0;
         out_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         src_ff       <= src_in;
         dst_ff       <= dst_in;
         pend_ff      <= pend_in;
         units_ff     <= units_in;
         src_cnt_ff   <= src_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff      <= pix_in;
      left_ff     <= left_in;
      weight_ff   <= weight_in;
      run_last_ff <= run_last_in;
      line_end_ff <= line_end_in;
      if (load_rsp) begin
         rsp_pix_ff <= div_quot;
         rsp_run_ff <= run_last_ff;
         rsp_end_ff <= line_end_ff;
      end
   end

   aalr_mac #(
      .ACC_W (ACC_W),
      .SZ_W  (SZ_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .weight (weight_in),
      .pixel  (pix_ff),
      .busy   (mac_busy),
      .acc    (mac_acc)
   );

   aalr_div #(
      .ACC_W (ACC_W),
      .SZ_W  (SZ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (s_used),
      .dividend (mac_acc),
      .busy     (div_busy),
      .quot     (div_quot)
   );

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.red_out   = rsp_pix_ff[CH_RED];
   assign rsp_ch.green_out = rsp_pix_ff[CH_GREEN];
   assign rsp_ch.blue_out  = rsp_pix_ff[CH_BLUE];
   assign rsp_ch.run_last  = rsp_run_ff;
   assign rsp_ch.line_end  = rsp_end_ff;

   // Between pixels the open output always holds less than one output's worth.
   `AALR_ASSERT_IMP(a_fill_below_src, state_ff == ST_IDLE, units_ff < s_used)
   `AALR_ASSERT_IMP(a_mac_in_state, mac_busy, state_ff == ST_MAC)
   `AALR_ASSERT_IMP(a_div_in_state, div_busy, state_ff == ST_DIV)
   // The last output of a line uses up the last source pixel.
   `AALR_ASSERT_IMP(a_line_end_closes_run, rsp_valid_ff && rsp_end_ff, rsp_run_ff)

endmodule

// File: rtl/aalr_mac.sv
// Bit-serial multiply-accumulate for the three color channels.
// One pixel bit per cycle; holds the running weighted sums. Depends on aalr_pkg.
module aalr_mac import aalr_pkg::*; #(
   parameter int ACC_W = 20,
   parameter int SZ_W  = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mac_ctl_type                      ctl,
   input  logic [SZ_W-1:0]                  weight,
   input  pixel_type                        pixel,
   output logic                             busy,
   output logic [NUM_CHAN-1:0][ACC_W-1:0]   acc
);

   localparam int CNT_W = $clog2(CHAN_W + 1);

   logic [NUM_CHAN-1:0][ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0]               mcand_ff, mcand_in;
   pixel_type                      mult_ff, mult_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;

   always_comb begin
      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      mult_in  = mult_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      if (ctl.start) begin
         mcand_in = ACC_W'(weight);
         mult_in  = pixel;
         cnt_in   = CNT_W'(CHAN_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // Add the shifted weight wherever the current pixel bit is set.
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (mult_ff[ch][0]) begin
               acc_in[ch] = acc_ff[ch] + mcand_ff;
            end
            mult_in[ch] = mult_ff[ch] >> 1;
         end
         mcand_in = mcand_ff << 1;
         cnt_in   = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
      if (ctl.clear) begin
         acc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      mcand_ff <= mcand_in;
      mult_ff  <= mult_in;
   end

   assign busy = busy_ff;
   assign acc  = acc_ff;

endmodule

// File: rtl/aalr_div.sv
// Restoring divider, one quotient bit per cycle, three lanes sharing a divisor.
// The dividend is known to be below 256 times the divisor. Depends on aalr_pkg.
module aalr_div import aalr_pkg::*; #(
   parameter int ACC_W = 20,
   parameter int SZ_W  = 13
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [SZ_W-1:0]                  divisor,
   input  logic [NUM_CHAN-1:0][ACC_W-1:0]   dividend,
   output logic                             busy,
   output pixel_type                        quot
);

   localparam int CNT_W = $clog2(CHAN_W + 1);

   logic [NUM_CHAN-1:0][ACC_W-1:0] rem_ff, rem_in;
   logic [ACC_W-1:0]               dv_ff, dv_in;
   pixel_type                      quot_ff, quot_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;

   always_comb begin
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = dividend;
         dv_in   = ACC_W'(divisor) << (CHAN_W - 1);
         quot_in = '0;
         cnt_in  = CNT_W'(CHAN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         for (int ch = 0; ch < NUM_CHAN; ch++) begin
            if (rem_ff[ch] >= dv_ff) begin
               rem_in[ch]  = rem_ff[ch] - dv_ff;
               quot_in[ch] = {quot_ff[ch][CHAN_W-2:0], 1'b1};
            end else begin
               quot_in[ch] = {quot_ff[ch][CHAN_W-2:0], 1'b0};
            end
         end
         dv_in  = dv_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
      rem_ff  <= rem_in;
      dv_ff   <= dv_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule
